// ===== src/dbm_pkg.sv =====
// ----------------------------------------------------------------------------
// dbm_pkg
// Shared constants, item codes and controller states for the divisibility
// bipartite matching unit.
// ----------------------------------------------------------------------------
`default_nettype none

package dbm_pkg;

  localparam int MAX_SIDE_DEF = 128;
  localparam int DATA_W       = 32;
  localparam int SIZE_W       = 8;

  localparam logic [1:0] MODE_FIRST  = 2'd0;
  localparam logic [1:0] MODE_SECOND = 2'd1;
  localparam logic [1:0] MODE_FINISH = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PAIR_WAIT,
    S_PAIR,
    S_DIV,
    S_BIT,
    S_ROOT,
    S_LOAD,
    S_SCAN,
    S_PCHK,
    S_POPW,
    S_POPL,
    S_AUGW,
    S_AUGWR,
    S_NEXT,
    S_EMIT
  } dbm_state_t;

endpackage

`default_nettype wire

// ===== src/dbm_divchk.sv =====
// ----------------------------------------------------------------------------
// dbm_divchk
// Bit-serial restoring remainder unit: tells whether an unsigned dividend is
// a multiple of a nonzero unsigned divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dbm_divchk
  import dbm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [DATA_W-1:0] dividend,
  input  wire logic [DATA_W-1:0] divisor,
  output logic                   done,
  output logic                   multiple
);

  localparam int CNT_W = $clog2(DATA_W);

  logic              run;
  logic [CNT_W-1:0]  cnt;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] dsh;
  logic [DATA_W-1:0] dvs;
  logic [DATA_W:0]   trial;
  logic [DATA_W-1:0] rem_next;

  always_comb begin
    trial = {rem, dsh[DATA_W-1]};
    if (trial >= {1'b0, dvs}) begin
      rem_next = DATA_W'(trial - {1'b0, dvs});
    end else begin
      rem_next = trial[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DATA_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dsh <= dividend;
      dvs <= divisor;
    end else if (run) begin
      rem <= rem_next;
      dsh <= {dsh[DATA_W-2:0], 1'b0};
    end
  end

  assign multiple = (rem == '0);

endmodule

`default_nettype wire

// ===== src/divisibility_bipartite_matching_unit.sv =====
// ----------------------------------------------------------------------------
// divisibility_bipartite_matching_unit
// Collects two lists of signed words, builds divisibility adjacency rows in a
// memory and runs an augmenting-path search with a stack memory, then emits
// the maximum matching size.
// ----------------------------------------------------------------------------
// append beats are taken while idle; a finish beat runs
//   row building for every pair (serial remainder unit, 32 steps),
//   then per root a column scan with push, pop and augment steps,
//   all through single-port memory reads
// reset clears counts, drop flag and control; list, row and stack memories
// hold garbage until written and need no clearing pass
`default_nettype none

module divisibility_bipartite_matching_unit
  import dbm_pkg::*;
#(
  parameter int MAX_SIDE = MAX_SIDE_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // value[31:0]
  input  wire logic [1:0]  s_tuser,   // mode[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata    // matching_size[7:0], overflowed[8], zeros
);

  localparam int IW  = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int CW  = $clog2(MAX_SIDE + 1);
  localparam int SD  = MAX_SIDE + 1;
  localparam int SAW = $clog2(SD);
  localparam int SPW = $clog2(SD + 1);
  localparam int SW  = IW + CW + IW;

  dbm_state_t state, state_next;

  logic [DATA_W-1:0]   first_mem [MAX_SIDE];
  logic [DATA_W-1:0]   second_mem [MAX_SIDE];
  logic [MAX_SIDE-1:0] edge_mem [MAX_SIDE];
  logic [IW-1:0]       partner_mem [MAX_SIDE];
  logic [SW-1:0]       stack_mem [SD];

  logic [CW-1:0]       first_count, second_count;
  logic                drop;
  logic [DATA_W-1:0]   a_q, b_q;
  logic [MAX_SIDE-1:0] edge_q, row_bits, row_new;
  logic [IW-1:0]       p_q;
  logic [SW-1:0]       stk_q;
  logic [MAX_SIDE-1:0] pvalid, seen;

  logic [IW-1:0]  i, j, r, cur_left;
  logic [CW-1:0]  cur_next, size;
  logic [SPW-1:0] sp;
  logic [SAW-1:0] stk_raddr;
  logic           pair_bit;
  logic [IW-1:0]  jn;

  logic              div_start, div_done, div_mult;
  logic [DATA_W-1:0] a_mag, b_mag;

  logic accept;
  logic [1:0]  mode;
  logic [31:0] value;

  assign mode     = s_tuser;
  assign value    = s_tdata;
  assign s_tready = (state == S_IDLE) && !m_tvalid;
  assign accept   = s_tvalid && s_tready;
  assign jn       = cur_next[IW-1:0];
  assign a_mag    = a_q[DATA_W-1] ? DATA_W'(-a_q) : a_q;
  assign b_mag    = b_q[DATA_W-1] ? DATA_W'(-b_q) : b_q;
  assign div_start = (state == S_PAIR) && (a_q != '0);
  assign row_new  = row_bits | (MAX_SIDE'(pair_bit) << j);

  dbm_divchk u_divchk (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (b_mag),
    .divisor  (a_mag),
    .done     (div_done),
    .multiple (div_mult)
  );

  // list memories
  always_ff @(posedge clk) begin
    if (accept && mode == MODE_FIRST && first_count != CW'(MAX_SIDE)) begin
      first_mem[first_count[IW-1:0]] <= value;
    end
    if (accept && mode == MODE_SECOND && second_count != CW'(MAX_SIDE)) begin
      second_mem[second_count[IW-1:0]] <= value;
    end
    a_q <= first_mem[i];
    b_q <= second_mem[j];
  end

  // adjacency rows
  always_ff @(posedge clk) begin
    if (state == S_BIT && CW'(j) == second_count - 1'b1) begin
      edge_mem[i] <= row_new;
    end
    edge_q <= edge_mem[cur_left];
  end

  // partner memory
  always_ff @(posedge clk) begin
    if (state == S_PCHK && !pvalid[jn]) begin
      partner_mem[jn] <= cur_left;
    end else if (state == S_AUGWR) begin
      partner_mem[stk_q[IW-1:0]] <= stk_q[SW-1 -: IW];
    end
    p_q <= partner_mem[jn];
  end

  // search stack memory
  always_ff @(posedge clk) begin
    if (state == S_PCHK && pvalid[jn] && sp <= SPW'(MAX_SIDE)) begin
      stack_mem[SAW'(sp - 1'b1)] <= {cur_left, CW'(cur_next + 1'b1), jn};
    end
    stk_q <= stack_mem[stk_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && mode == MODE_FINISH) begin
          if (first_count == '0 || second_count == '0) state_next = S_EMIT;
          else state_next = S_PAIR_WAIT;
        end
      end
      S_PAIR_WAIT: state_next = S_PAIR;
      S_PAIR: state_next = (a_q == '0) ? S_BIT : S_DIV;
      S_DIV: if (div_done) state_next = S_BIT;
      S_BIT: begin
        if (CW'(j) == second_count - 1'b1 && CW'(i) == first_count - 1'b1) begin
          state_next = S_ROOT;
        end else begin
          state_next = S_PAIR_WAIT;
        end
      end
      S_ROOT: state_next = S_LOAD;
      S_LOAD: state_next = S_SCAN;
      S_SCAN: begin
        if (cur_next >= second_count) begin
          state_next = (sp == SPW'(1)) ? S_NEXT : S_POPW;
        end else if (edge_q[jn] && !seen[jn]) begin
          state_next = S_PCHK;
        end
      end
      S_PCHK: begin
        if (!pvalid[jn]) state_next = (sp == SPW'(1)) ? S_NEXT : S_AUGW;
        else if (sp > SPW'(MAX_SIDE)) state_next = S_SCAN;
        else state_next = S_LOAD;
      end
      S_POPW: state_next = S_POPL;
      S_POPL: state_next = S_LOAD;
      S_AUGW: state_next = S_AUGWR;
      S_AUGWR: state_next = (stk_raddr == '0) ? S_NEXT : S_AUGW;
      S_NEXT: state_next = (CW'(r) == first_count - 1'b1) ? S_EMIT : S_ROOT;
      S_EMIT: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      first_count  <= '0;
      second_count <= '0;
      drop         <= 1'b0;
      m_tvalid     <= 1'b0;
      pvalid       <= '0;
      seen         <= '0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (accept && mode == MODE_FIRST) begin
        if (first_count == CW'(MAX_SIDE)) drop <= 1'b1;
        else first_count <= first_count + 1'b1;
      end
      if (accept && mode == MODE_SECOND) begin
        if (second_count == CW'(MAX_SIDE)) drop <= 1'b1;
        else second_count <= second_count + 1'b1;
      end
      if (accept && mode == MODE_FINISH) pvalid <= '0;
      if (state == S_ROOT) seen <= '0;
      if (state == S_SCAN && cur_next < second_count && edge_q[jn] && !seen[jn]) begin
        seen[jn] <= 1'b1;
      end
      if (state == S_PCHK && !pvalid[jn]) pvalid[jn] <= 1'b1;
      if (state == S_EMIT) begin
        m_tvalid     <= 1'b1;
        first_count  <= '0;
        second_count <= '0;
        drop         <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        i        <= '0;
        j        <= '0;
        r        <= '0;
        size     <= '0;
        row_bits <= '0;
      end
      S_PAIR: begin
        if (a_q == '0) pair_bit <= (b_q == '0);
      end
      S_DIV: begin
        if (div_done) pair_bit <= div_mult;
      end
      S_BIT: begin
        if (CW'(j) == second_count - 1'b1) begin
          j        <= '0;
          row_bits <= '0;
          i        <= i + 1'b1;
        end else begin
          j        <= j + 1'b1;
          row_bits <= row_new;
        end
      end
      S_ROOT: begin
        sp       <= SPW'(1);
        cur_left <= r;
        cur_next <= '0;
      end
      S_SCAN: begin
        if (cur_next >= second_count) begin
          sp        <= sp - 1'b1;
          stk_raddr <= SAW'(sp - SPW'(2));
        end else if (!(edge_q[jn] && !seen[jn])) begin
          cur_next <= cur_next + 1'b1;
        end
      end
      S_PCHK: begin
        if (!pvalid[jn]) begin
          stk_raddr <= SAW'(sp - SPW'(2));
          if (sp == SPW'(1)) size <= size + 1'b1;
        end else if (sp > SPW'(MAX_SIDE)) begin
          cur_next <= cur_next + 1'b1;
        end else begin
          sp       <= sp + 1'b1;
          cur_left <= p_q;
          cur_next <= '0;
        end
      end
      S_POPL: begin
        cur_left <= stk_q[SW-1 -: IW];
        cur_next <= stk_q[IW +: CW];
      end
      S_AUGWR: begin
        if (stk_raddr == '0) size <= size + 1'b1;
        else stk_raddr <= stk_raddr - 1'b1;
      end
      S_NEXT: begin
        r <= r + 1'b1;
      end
      S_EMIT: begin
        m_tdata <= {7'b0, drop, SIZE_W'(size)};
      end
      default: begin
      end
    endcase
  end

  assert property (@(posedge clk) disable iff (rst)
    first_count <= CW'(MAX_SIDE) && second_count <= CW'(MAX_SIDE))
    else $error("list count beyond capacity");

  assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> sp >= SPW'(1) && sp <= SPW'(SD))
    else $error("search stack depth out of range");

  assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT |=> m_tvalid)
    else $error("result beat not presented after emit");

  assert property (@(posedge clk) disable iff (rst)
    state == S_NEXT |-> size <= first_count)
    else $error("matching size exceeds first list count");

endmodule

`default_nettype wire
